/* rtl/core/lcc_pkg.sv */
// shared types, constants and mod-10 helpers for the luhn card number classifier
package lcc_pkg;

  localparam int MAX_DIGITS_DEF = 19;
  localparam int DIGIT_W        = 4;
  localparam int LEN_W          = 5;
  localparam int PREFIX_W       = 8;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 8;

  localparam logic [PREFIX_W-1:0] PFX_AMEX_A  = 8'd34;
  localparam logic [PREFIX_W-1:0] PFX_AMEX_B  = 8'd37;
  localparam logic [PREFIX_W-1:0] PFX_MC_LO   = 8'd51;
  localparam logic [PREFIX_W-1:0] PFX_MC_HI   = 8'd55;
  localparam logic [DIGIT_W-1:0]  VISA_DIGIT  = 4'd4;
  localparam logic [LEN_W-1:0]    LEN_AMEX    = 5'd15;
  localparam logic [LEN_W-1:0]    LEN_SHORT   = 5'd13;
  localparam logic [LEN_W-1:0]    LEN_LONG    = 5'd16;

  typedef enum logic [1:0] {
    CLS_INVALID = 2'd0,
    CLS_AMEX    = 2'd1,
    CLS_MC      = 2'd2,
    CLS_VISA    = 2'd3
  } card_class_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic               ok;
    logic [DIGIT_W-1:0] first;
    logic [DIGIT_W-1:0] second;
  } acc_info_t;

  // packed lowest field last: card_class in bits 1:0
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ok;
    card_class_t      cls;
  } result_t;

  function automatic logic [DIGIT_W-1:0] mod10_plain(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= 4'd10) ? d - 4'd10 : d;
    return r;
  endfunction

  function automatic logic [DIGIT_W-1:0] mod10_double(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] t;
    t = {d, 1'b0};
    if (t >= 5'd10) begin
      t = t - 5'd9;
    end
    if (t >= 5'd20) begin
      t = t - 5'd20;
    end else if (t >= 5'd10) begin
      t = t - 5'd10;
    end
    return t[DIGIT_W-1:0];
  endfunction

  function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                    input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[DIGIT_W-1:0];
  endfunction

endpackage

/* rtl/core/luhn_card_number_classifier.sv */
// top level: luhn check and card type of a digit stream
//
//  channel | direction | tdata (low bit up)              | tlast
//  in_     | slave     | digit[3:0], zero pad [7:4]      | last digit of number
//  out_    | master    | card_class[1:0], ok[2], len[7:3] | -
//
// one digit accepted per cycle unless a last digit is held back by a stalled result; the
// last digit goes through an input register feeding the mod-10 update to an output
// register that holds the result and raises out_tvalid; other digits keep flowing
// synchronous active-low reset clears sums, count, prefix and both valid flags
module luhn_card_number_classifier #(
  parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lcc_pkg::IN_TDATA_W-1:0]    in_tdata,   // digit[3:0], zero[7:4]
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lcc_pkg::OUT_TDATA_W-1:0]   out_tdata   // card_class[1:0], ok[2], length[7:3]
);

  logic                        s1_valid_r, s1_valid_nxt;
  logic [lcc_pkg::DIGIT_W-1:0] s1_digit_r;
  logic                        s1_last_r;
  logic                        out_valid_r, out_valid_nxt;
  lcc_pkg::result_t            out_data_r;

  logic                        in_acc, out_free, adv, load_out;
  lcc_pkg::acc_info_t          info;
  lcc_pkg::card_class_t        cls;

  lcc_accum #(.MAX_DIGITS(MAX_DIGITS)) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .digit (s1_digit_r),
    .last  (s1_last_r),
    .info  (info)
  );

  lcc_classify u_classify (
    .info (info),
    .cls  (cls)
  );

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    adv       = s1_valid_r && (!s1_last_r || out_free);
    in_tready = !s1_valid_r || adv;
    in_acc    = in_tvalid && in_tready;
    load_out  = adv && s1_last_r;

    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_digit_r <= in_tdata[lcc_pkg::DIGIT_W-1:0];
      s1_last_r  <= in_tlast;
    end
    if (load_out) begin
      out_data_r.len <= info.len;
      out_data_r.ok  <= info.ok;
      out_data_r.cls <= cls;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_class_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.cls != lcc_pkg::CLS_INVALID) |-> out_data_r.ok)
    else $error("card class reported on a failed checksum");

  a_amex_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.cls == lcc_pkg::CLS_AMEX) |-> out_data_r.len == lcc_pkg::LEN_AMEX)
    else $error("amex result with wrong length");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.len != '0 &&
                     out_data_r.len <= lcc_pkg::LEN_W'(MAX_DIGITS)))
    else $error("result length out of range");

  a_last_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while a last digit is held back");
`endif

endmodule

/* rtl/core/lcc_accum.sv */
// running luhn sums, digit count and prefix capture for one card number
module lcc_accum #(
  parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [lcc_pkg::DIGIT_W-1:0]  digit,
  input  logic                         last,
  output lcc_pkg::acc_info_t           info
);

  localparam logic [lcc_pkg::LEN_W-1:0] MAX_CNT = lcc_pkg::LEN_W'(MAX_DIGITS);

  logic [lcc_pkg::DIGIT_W-1:0] sum_even_r, sum_even_nxt;
  logic [lcc_pkg::DIGIT_W-1:0] sum_odd_r, sum_odd_nxt;
  logic [lcc_pkg::LEN_W-1:0]   count_r, count_nxt;
  logic [lcc_pkg::DIGIT_W-1:0] first_r, first_nxt;
  logic [lcc_pkg::DIGIT_W-1:0] second_r, second_nxt;

  logic [lcc_pkg::DIGIT_W-1:0] new_even, new_odd, first_sel, second_sel;
  logic [lcc_pkg::LEN_W-1:0]   count_inc;

  always_comb begin
    new_odd    = lcc_pkg::add_mod10(sum_even_r, lcc_pkg::mod10_plain(digit));
    new_even   = lcc_pkg::add_mod10(sum_odd_r, lcc_pkg::mod10_double(digit));
    first_sel  = (count_r == '0) ? digit : first_r;
    second_sel = (count_r == lcc_pkg::LEN_W'(1)) ? digit : second_r;
    count_inc  = (count_r < MAX_CNT) ? count_r + lcc_pkg::LEN_W'(1) : count_r;

    info.len    = count_inc;
    info.ok     = (new_odd == '0);
    info.first  = first_sel;
    info.second = second_sel;

    sum_even_nxt = sum_even_r;
    sum_odd_nxt  = sum_odd_r;
    count_nxt    = count_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    if (step) begin
      if (last) begin
        sum_even_nxt = '0;
        sum_odd_nxt  = '0;
        count_nxt    = '0;
        first_nxt    = '0;
        second_nxt   = '0;
      end else begin
        sum_even_nxt = new_even;
        sum_odd_nxt  = new_odd;
        count_nxt    = count_inc;
        first_nxt    = first_sel;
        second_nxt   = second_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_even_r <= '0;
      sum_odd_r  <= '0;
      count_r    <= '0;
      first_r    <= '0;
      second_r   <= '0;
    end else begin
      sum_even_r <= sum_even_nxt;
      sum_odd_r  <= sum_odd_nxt;
      count_r    <= count_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
    end
  end

endmodule

/* rtl/core/lcc_classify.sv */
// card type decision from length, prefix and luhn verdict
module lcc_classify (
  input  lcc_pkg::acc_info_t  info,
  output lcc_pkg::card_class_t cls
);

  logic [lcc_pkg::PREFIX_W-1:0] prefix;

  always_comb begin
    prefix = lcc_pkg::PREFIX_W'(info.first) * lcc_pkg::PREFIX_W'(10)
           + lcc_pkg::PREFIX_W'(info.second);
    cls = lcc_pkg::CLS_INVALID;
    priority if (!info.ok) begin
      cls = lcc_pkg::CLS_INVALID;
    end else if (info.len == lcc_pkg::LEN_AMEX &&
                 (prefix == lcc_pkg::PFX_AMEX_A || prefix == lcc_pkg::PFX_AMEX_B)) begin
      cls = lcc_pkg::CLS_AMEX;
    end else if (info.len == lcc_pkg::LEN_LONG &&
                 prefix >= lcc_pkg::PFX_MC_LO && prefix <= lcc_pkg::PFX_MC_HI) begin
      cls = lcc_pkg::CLS_MC;
    end else if ((info.len == lcc_pkg::LEN_SHORT || info.len == lcc_pkg::LEN_LONG) &&
                 info.first == lcc_pkg::VISA_DIGIT) begin
      cls = lcc_pkg::CLS_VISA;
    end else begin
      cls = lcc_pkg::CLS_INVALID;
    end
  end

endmodule

/* tb/luhn_card_number_classifier_tb.sv */
// testbench for the luhn card number classifier: streams card numbers, checks every verdict
`timescale 1ns / 100ps

module luhn_card_number_classifier_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 180;

  typedef enum int {
    KIND_AMEX,
    KIND_MC,
    KIND_VISA
  } card_kind_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [lcc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [lcc_pkg::OUT_TDATA_W-1:0] out_tdata;

  lcc_pkg::result_t pending_verdicts[$];
  logic [3:0]  number_digits[$];
  logic [3:0]  acc_even;
  logic [3:0]  acc_odd;
  int          digits_seen;
  logic [3:0]  lead_digit;
  logic [3:0]  next_digit;
  int          digits_sent;
  int          mismatches;
  int          cycles;
  bit          send_gaps_on;
  bit          recv_gaps_on;
  bit          hold_off;
  bit          holding;

  luhn_card_number_classifier uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int luhn_term(input logic [3:0] d, input bit doubled);
    int t;
    t = d;
    if (doubled) begin
      t = 2 * t;
      if (t >= 10) t = t - 9;
    end
    return t % 10;
  endfunction

  task track_digit(input logic [3:0] d, input logic is_last);
    logic [3:0]        odd_next;
    int                prefix;
    lcc_pkg::result_t  verdict;
    odd_next = (acc_even + luhn_term(d, 1'b0)) % 10;
    acc_even = (acc_odd + luhn_term(d, 1'b1)) % 10;
    acc_odd  = odd_next;
    if (digits_seen == 0) lead_digit = d;
    else if (digits_seen == 1) next_digit = d;
    if (digits_seen < lcc_pkg::MAX_DIGITS_DEF) digits_seen++;
    if (is_last) begin
      prefix      = lead_digit * 10 + next_digit;
      verdict.len = digits_seen[lcc_pkg::LEN_W-1:0];
      verdict.ok  = (acc_odd == 4'd0);
      verdict.cls = lcc_pkg::CLS_INVALID;
      if (verdict.ok) begin
        if (verdict.len == lcc_pkg::LEN_AMEX &&
            (prefix == lcc_pkg::PFX_AMEX_A || prefix == lcc_pkg::PFX_AMEX_B))
          verdict.cls = lcc_pkg::CLS_AMEX;
        else if (verdict.len == lcc_pkg::LEN_LONG &&
                 prefix >= lcc_pkg::PFX_MC_LO && prefix <= lcc_pkg::PFX_MC_HI)
          verdict.cls = lcc_pkg::CLS_MC;
        else if ((verdict.len == lcc_pkg::LEN_SHORT || verdict.len == lcc_pkg::LEN_LONG) &&
                 lead_digit == lcc_pkg::VISA_DIGIT)
          verdict.cls = lcc_pkg::CLS_VISA;
      end
      pending_verdicts.push_back(verdict);
      acc_even    = 4'd0;
      acc_odd     = 4'd0;
      digits_seen = 0;
      lead_digit  = 4'd0;
      next_digit  = 4'd0;
    end
  endtask

  task send_digit(input logic [3:0] d, input logic is_last);
    int gap;
    gap = send_gaps_on ? rand_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, d};
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_digit(d, is_last);
    digits_sent++;
  endtask

  task send_number();
    for (int i = 0; i < number_digits.size(); i++) begin
      send_digit(number_digits[i], i == number_digits.size() - 1);
    end
  endtask

  // digits after the prefix are random, the final one sets the checksum for three digits or more
  task build_number(input int lead, input int second_d, input int len, input bit valid,
                    input bit wide_digits);
    int s;
    int chk;
    int n;
    number_digits.delete();
    for (int i = 0; i < len; i++) begin
      if (i == 0) number_digits.push_back(lead[3:0]);
      else if (i == 1) number_digits.push_back(second_d[3:0]);
      else if (wide_digits) number_digits.push_back($urandom_range(0, 15));
      else number_digits.push_back($urandom_range(0, 9));
    end
    n = number_digits.size();
    if (n >= 3) begin
      number_digits[n-1] = 4'd0;
      s = 0;
      for (int i = 0; i < n; i++) begin
        s += luhn_term(number_digits[i], ((n - 1 - i) % 2) == 1);
      end
      chk = (10 - (s % 10)) % 10;
      if (!valid) chk = (chk + $urandom_range(1, 9)) % 10;
      number_digits[n-1] = chk[3:0];
    end
  endtask

  task build_card(input card_kind_t kind, input bit valid);
    case (kind)
      KIND_AMEX: build_number(3, $urandom_range(0, 1) ? 4 : 7, 15, valid, 1'b0);
      KIND_MC:   build_number(5, $urandom_range(1, 5), 16, valid, 1'b0);
      default:   build_number(4, $urandom_range(0, 9), $urandom_range(0, 1) ? 13 : 16,
                              valid, 1'b0);
    endcase
  endtask

  task wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, always ready when gaps are off, a long hold-off on request
  initial begin
    int g;
    out_tready <= 1'b0;
    forever begin
      if (hold_off) begin
        holding = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        holding  = 1'b0;
      end else if (!recv_gaps_on) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        g = rand_gap();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    lcc_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[1:0] !== want.cls || out_tdata[2] !== want.ok ||
            out_tdata[7:3] !== want.len) begin
          if (mismatches < 10)
            $display("mismatch: expected class %0d ok %0b len %0d, got class %0d ok %0b len %0d",
                     want.cls, want.ok, want.len, out_tdata[1:0], out_tdata[2], out_tdata[7:3]);
          mismatches++;
        end
      end
    end
  end

  task test_single_digits();
    build_number(0, 0, 1, 1'b1, 1'b0);
    send_number();
    build_number(9, 0, 1, 1'b1, 1'b0);
    send_number();
    build_number(10, 0, 1, 1'b1, 1'b0);
    send_number();
    build_number(15, 0, 1, 1'b1, 1'b0);
    send_number();
    build_number(4, 15, 2, 1'b1, 1'b0);
    send_number();
  endtask

  task test_short_visa();
    build_number(4, 0, 13, 1'b1, 1'b0);
    send_number();
  endtask

  task test_card_classes();
    for (int i = 0; i < 36; i++) begin
      build_card(card_kind_t'(i % 3), (i % 4) != 3);
      send_number();
    end
  endtask

  task test_near_misses();
    for (int i = 0; i < 12; i++) begin
      case (i)
        0:  build_number(3, 4, 16, 1'b1, 1'b0);
        1:  build_number(3, 7, 14, 1'b1, 1'b0);
        2:  build_number(3, 3, 15, 1'b1, 1'b0);
        3:  build_number(3, 8, 15, 1'b1, 1'b0);
        4:  build_number(5, 0, 16, 1'b1, 1'b0);
        5:  build_number(5, 6, 16, 1'b1, 1'b0);
        6:  build_number(5, 5, 15, 1'b1, 1'b0);
        7:  build_number(5, 1, 13, 1'b1, 1'b0);
        8:  build_number(4, 9, 15, 1'b1, 1'b0);
        9:  build_number(4, 2, 12, 1'b1, 1'b0);
        10: build_number(0, 4, 16, 1'b1, 1'b0);
        default: build_number(4, 0, 19, 1'b1, 1'b0);
      endcase
      send_number();
    end
  endtask

  // counts past the saturation point and digits above nine
  task test_long_numbers();
    for (int len = 17; len <= 26; len++) begin
      build_number($urandom_range(0, 9), $urandom_range(0, 9), len, len[0], len > 21);
      send_number();
    end
  endtask

  task test_backpressure_fill();
    in_tvalid <= 1'b0;
    hold_off = 1'b1;
    while (!holding) @(posedge clk);
    send_gaps_on = 1'b0;
    for (int i = 0; i < 30; i++) begin
      build_number($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(1, 3),
                   1'b1, 1'b0);
      send_number();
    end
    send_gaps_on = 1'b1;
    wait_drained();
  endtask

  task test_no_idle_burst();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (i % 2) build_card(card_kind_t'($urandom_range(0, 2)), 1'b1);
      else build_number($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(1, 4),
                        1'b1, 1'b1);
      send_number();
    end
    wait_drained();
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
  endtask

  task test_random_mix();
    int start;
    int r;
    start = digits_sent;
    while (digits_sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) build_card(card_kind_t'($urandom_range(0, 2)), $urandom_range(0, 4) != 0);
      else if (r < 70) build_number($urandom_range(3, 5), $urandom_range(0, 9),
                                    $urandom_range(12, 17), 1'b1, 1'b0);
      else if (r < 85) build_number($urandom_range(0, 9), $urandom_range(0, 9),
                                    $urandom_range(1, 24), $urandom_range(0, 1), 1'b0);
      else build_number($urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(1, 24), $urandom_range(0, 1), 1'b1);
      send_number();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tlast     <= 1'b0;
    acc_even     = 4'd0;
    acc_odd      = 4'd0;
    digits_seen  = 0;
    lead_digit   = 4'd0;
    next_digit   = 4'd0;
    digits_sent  = 0;
    mismatches   = 0;
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
    hold_off     = 1'b0;
    holding      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_single_digits();
    test_short_visa();
    test_card_classes();
    test_near_misses();
    test_long_numbers();
    test_backpressure_fill();
    test_no_idle_burst();
    test_random_mix();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lcc_pkg.sv
rtl/core/lcc_accum.sv
rtl/core/lcc_classify.sv
rtl/core/luhn_card_number_classifier.sv
tb/luhn_card_number_classifier_tb.sv
